>>> hw/rtl/tksrs_pkg.sv
// ----------------------------------------------------------------------------
// tksrs_pkg: shared types and helpers for the two-key stable record sorter
// Holds the record type, the cell control group and the key compare used by
// every cell of the sorting chain.
// ----------------------------------------------------------------------------
package tksrs_pkg;

  localparam int MAX_RECORDS = 64;
  localparam int KEY_WIDTH   = 16;
  localparam int FIELD_W     = 16;

  typedef logic signed [KEY_WIDTH-1:0] key_t;
  typedef logic [FIELD_W-1:0]          field_t;

  typedef struct packed {
    field_t move;
    key_t   pri;
    key_t   sec;
  } rec_t;

  // Per-cycle command broadcast to every cell.
  typedef struct packed {
    logic ins;    // insert the beat on the input channel
    logic drain;  // shift the chain one place toward cell zero
  } cell_ctl_t;

  typedef enum logic {
    ST_COLLECT,
    ST_DRAIN
  } state_t;

  // A key is the low KEY_WIDTH bits of the field; a wider key zero-extends.
  function automatic key_t to_key(input field_t raw);
    logic [31:0] w;
    begin
      w = 32'(raw);
      return key_t'(w);
    end
  endfunction

  // Back to the 16-bit field: sign-extend, then keep the low field bits.
  function automatic field_t from_key(input key_t k);
    logic signed [31:0] e;
    begin
      e = 32'(k);
      return e[FIELD_W-1:0];
    end
  endfunction

  // True when record a strictly beats record b (descending, two keys).
  function automatic logic beats(input rec_t a, input rec_t b);
    begin
      if (a.pri != b.pri) return a.pri > b.pri;
      return a.sec > b.sec;
    end
  endfunction

endpackage

>>> hw/rtl/tksrs_cell.sv
// ----------------------------------------------------------------------------
// tksrs_cell: one slot of the insertion chain
// Holds one record and its valid bit. On insert it keeps its record, takes
// the new one or takes its left neighbor's; on drain it takes its right one.
// ----------------------------------------------------------------------------
module tksrs_cell import tksrs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cell_ctl_t ctl,
  input  rec_t      new_rec,
  input  rec_t      prev_rec,
  input  logic      prev_valid,
  input  logic      prev_take,
  input  rec_t      next_rec,
  input  logic      next_valid,
  output rec_t      rec,
  output logic      valid,
  output logic      take
);

  rec_t rec_r, rec_nxt;
  logic valid_r, valid_nxt;

  // The new record lands here or to the left when this slot is empty or
  // holds a record the new one strictly beats; equal records stay ahead.
  assign take = !valid_r || beats(new_rec, rec_r);

  always_comb begin
    rec_nxt   = rec_r;
    valid_nxt = valid_r;
    if (ctl.ins) begin
      if (take) begin
        rec_nxt   = prev_take ? prev_rec : new_rec;
        valid_nxt = valid_r | prev_valid;
      end
    end else if (ctl.drain) begin
      rec_nxt   = next_rec;
      valid_nxt = next_valid;
    end
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign rec   = rec_r;
  assign valid = valid_r;

endmodule

>>> hw/rtl/tksrs_ctrl.sv
// ----------------------------------------------------------------------------
// tksrs_ctrl: run sequencer for the sorter
// Collects beats until the last one of a run, then drains the chain one
// record per accepted output beat, and keeps the overflow flag of the run.
// ----------------------------------------------------------------------------
module tksrs_ctrl import tksrs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_last,
  input  logic      out_ready,
  input  logic      full,
  input  logic      more_after_head,
  output logic      in_ready,
  output logic      out_valid,
  output logic      dropped,
  output cell_ctl_t ctl
);

  state_t state_r, state_nxt;
  logic   dropped_r, dropped_nxt;
  logic   in_fire, out_fire, drain_done;

  assign in_fire    = in_valid && in_ready;
  assign out_fire   = out_valid && out_ready;
  assign drain_done = out_fire && !more_after_head;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_COLLECT: if (in_fire && in_last) state_nxt = ST_DRAIN;
      ST_DRAIN:   if (drain_done) state_nxt = ST_COLLECT;
      default:    state_nxt = ST_COLLECT;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    ctl       = '0;
    case (state_r)
      ST_COLLECT: begin
        in_ready = 1'b1;
        ctl.ins  = in_valid && !full;
      end
      ST_DRAIN: begin
        out_valid = 1'b1;
        ctl.drain = out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    dropped_nxt = dropped_r;
    if (drain_done) begin
      dropped_nxt = 1'b0;
    end else if (in_fire && full) begin
      dropped_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_COLLECT;
      dropped_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      dropped_r <= dropped_nxt;
    end
  end

  assign dropped = dropped_r;

endmodule

>>> hw/rtl/two_key_stable_record_sorter.sv
// ----------------------------------------------------------------------------
// two_key_stable_record_sorter: streaming insertion sorter, two signed keys
// Sorts a run of records descending by primary, then secondary score, stable.
// ----------------------------------------------------------------------------
// Usage: each input beat is inserted into a chain of MAX_RECORDS cells in the
// cycle it is accepted, so records of a run may arrive back to back, one per
// cycle. The beat flagged last is inserted too, and then the chain drains
// from its head: one sorted record per accepted output beat, so a run that
// holds n records needs n accepted output beats, during which in_ready is low. Input
// is taken again in the cycle after the beat carrying out_last_out. Records
// that arrive when all cells are full are dropped, and out_overflow is high
// on every output beat of that run.
module two_key_stable_record_sorter import tksrs_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  input  field_t in_move_code,
  input  field_t in_primary_score,
  input  field_t in_secondary_score,
  input  logic   in_last_record,
  output logic   out_valid,
  input  logic   out_ready,
  output field_t out_move_code_res,
  output field_t out_primary_score_res,
  output field_t out_secondary_score_res,
  output logic   out_last_out,
  output logic   out_overflow
);

  cell_ctl_t              ctl;
  rec_t                   new_rec;
  rec_t                   cell_rec  [MAX_RECORDS];
  logic [MAX_RECORDS-1:0] cell_valid;
  logic [MAX_RECORDS-1:0] cell_take;
  logic                   dropped;

  assign new_rec.move = in_move_code;
  assign new_rec.pri  = to_key(in_primary_score);
  assign new_rec.sec  = to_key(in_secondary_score);

  for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
    rec_t prev_rec, next_rec;
    logic prev_valid, prev_take, next_valid;

    if (i == 0) begin : g_head
      assign prev_rec   = new_rec;
      assign prev_valid = 1'b1;
      assign prev_take  = 1'b0;
    end else begin : g_body
      assign prev_rec   = cell_rec[i-1];
      assign prev_valid = cell_valid[i-1];
      assign prev_take  = cell_take[i-1];
    end

    if (i == MAX_RECORDS - 1) begin : g_tail
      assign next_rec   = new_rec;
      assign next_valid = 1'b0;
    end else begin : g_inner
      assign next_rec   = cell_rec[i+1];
      assign next_valid = cell_valid[i+1];
    end

    tksrs_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .new_rec    (new_rec),
      .prev_rec   (prev_rec),
      .prev_valid (prev_valid),
      .prev_take  (prev_take),
      .next_rec   (next_rec),
      .next_valid (next_valid),
      .rec        (cell_rec[i]),
      .valid      (cell_valid[i]),
      .take       (cell_take[i])
    );
  end

  tksrs_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_last         (in_last_record),
    .out_ready       (out_ready),
    .full            (cell_valid[MAX_RECORDS-1]),
    .more_after_head (cell_valid[1]),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .dropped         (dropped),
    .ctl             (ctl)
  );

  // The head cell is the output register of the result channel.
  assign out_move_code_res       = cell_rec[0].move;
  assign out_primary_score_res   = from_key(cell_rec[0].pri);
  assign out_secondary_score_res = from_key(cell_rec[0].sec);
  assign out_last_out            = !cell_valid[1];
  assign out_overflow            = dropped;

  // Valid cells always form a prefix of the chain.
  a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    ((cell_valid >> 1) & ~cell_valid) == '0)
    else $error("valid cells do not form a prefix");

  // A result beat is only offered from an occupied head cell.
  a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cell_valid[0])
    else $error("result offered from an empty head cell");

  // The two front records are in order.
  a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    cell_valid[1] |-> !beats(cell_rec[1], cell_rec[0]))
    else $error("head records out of order");

  // After the final beat of a run the chain is empty and the flag cleared.
  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last_out) |=>
      (!out_valid && !out_overflow && !cell_valid[0]))
    else $error("state left over after the end of a run");

endmodule

>>> tb/sorted_run_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_run_checker: watches both channels of the record sorter
// Keeps its own stable two-key ordering of the records of the current run and
// compares every output beat against the oldest sorted record still owed.
// ----------------------------------------------------------------------------
module sorted_run_checker import tksrs_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  input  logic   in_ready,
  input  field_t in_move_code,
  input  field_t in_primary_score,
  input  field_t in_secondary_score,
  input  logic   in_last_record,
  input  logic   out_valid,
  input  logic   out_ready,
  input  field_t out_move_code_res,
  input  field_t out_primary_score_res,
  input  field_t out_secondary_score_res,
  input  logic   out_last_out,
  input  logic   out_overflow,
  output int     pending,
  output int     errors
);

  typedef struct {
    rec_t rec;
    logic fin;
    logic ovf;
  } sorted_beat_t;

  rec_t         held_q[$];
  logic         run_dropped;
  sorted_beat_t sorted_q[$];
  int           printed;

  initial begin
    pending     = 0;
    errors      = 0;
    printed     = 0;
    run_dropped = 1'b0;
  end

  task automatic report_mismatch(string what);
    errors++;
    if (printed < 50) begin
      $display("%0t ns: mismatch: %s", $time, what);
      printed++;
    end
  endtask

  // Descending on the primary key, then on the secondary key; equal keys lose.
  function automatic bit outranks(rec_t a, rec_t b);
    if (a.pri == b.pri) return signed'(a.sec) > signed'(b.sec);
    return signed'(a.pri) > signed'(b.pri);
  endfunction

  task automatic take_record(rec_t r, logic fin);
    int           slot;
    sorted_beat_t beat;
    if (held_q.size() >= MAX_RECORDS) begin
      run_dropped = 1'b1;
    end else begin
      // Walk up from the tail only past records that the new one strictly beats.
      slot = held_q.size();
      while (slot > 0 && outranks(r, held_q[slot-1])) slot--;
      held_q.insert(slot, r);
    end
    if (fin) begin
      foreach (held_q[k]) begin
        beat.rec = held_q[k];
        beat.fin = (k == held_q.size() - 1);
        beat.ovf = run_dropped;
        sorted_q.push_back(beat);
      end
      held_q.delete();
      run_dropped = 1'b0;
    end
  endtask

  task automatic check_beat();
    sorted_beat_t want;
    if (sorted_q.size() == 0) begin
      report_mismatch($sformatf("output beat with nothing owed, move %h",
                                out_move_code_res));
      return;
    end
    want = sorted_q.pop_front();
    if (out_move_code_res !== want.rec.move)
      report_mismatch($sformatf("move code %h, want %h", out_move_code_res, want.rec.move));
    if (out_primary_score_res !== field_t'(want.rec.pri))
      report_mismatch($sformatf("primary %h, want %h (move %h)",
                                out_primary_score_res, want.rec.pri, want.rec.move));
    if (out_secondary_score_res !== field_t'(want.rec.sec))
      report_mismatch($sformatf("secondary %h, want %h (move %h)",
                                out_secondary_score_res, want.rec.sec, want.rec.move));
    if (out_last_out !== want.fin)
      report_mismatch($sformatf("last flag %b, want %b (move %h)",
                                out_last_out, want.fin, want.rec.move));
    if (out_overflow !== want.ovf)
      report_mismatch($sformatf("overflow %b, want %b (move %h)",
                                out_overflow, want.ovf, want.rec.move));
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        take_record('{move: in_move_code, pri: key_t'(in_primary_score),
                      sec: key_t'(in_secondary_score)}, in_last_record);
      if (out_valid && out_ready) check_beat();
      pending = sorted_q.size();
    end
  end

endmodule

>>> tb/tb_two_key_stable_record_sorter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_two_key_stable_record_sorter: stimulus and verdict for the record sorter
// Sends directed runs (key extremes, ties, stability) and then random runs of
// mostly short length plus a few that fill or overrun the store, with random
// gaps and output stalls. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_two_key_stable_record_sorter;
  import tksrs_pkg::*;

  localparam int RUN_LIMIT   = 200000;
  localparam int ITEM_TARGET = 350;

  logic   clk = 1'b0;
  logic   rst_n;
  logic   in_valid;
  logic   in_ready;
  field_t in_move_code;
  field_t in_primary_score;
  field_t in_secondary_score;
  logic   in_last_record;
  logic   out_valid;
  logic   out_ready;
  field_t out_move_code_res;
  field_t out_primary_score_res;
  field_t out_secondary_score_res;
  logic   out_last_out;
  logic   out_overflow;

  logic   in_took = 1'b0;
  bit     calm = 1'b0;
  int     cycles = 0;
  int     sent = 0;
  int     pending;
  int     errors;

  always #1 clk = ~clk;

  two_key_stable_record_sorter DUT (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_ready                (in_ready),
    .in_move_code            (in_move_code),
    .in_primary_score        (in_primary_score),
    .in_secondary_score      (in_secondary_score),
    .in_last_record          (in_last_record),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_move_code_res       (out_move_code_res),
    .out_primary_score_res   (out_primary_score_res),
    .out_secondary_score_res (out_secondary_score_res),
    .out_last_out            (out_last_out),
    .out_overflow            (out_overflow)
  );

  sorted_run_checker u_checker (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_ready                (in_ready),
    .in_move_code            (in_move_code),
    .in_primary_score        (in_primary_score),
    .in_secondary_score      (in_secondary_score),
    .in_last_record          (in_last_record),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_move_code_res       (out_move_code_res),
    .out_primary_score_res   (out_primary_score_res),
    .out_secondary_score_res (out_secondary_score_res),
    .out_last_out            (out_last_out),
    .out_overflow            (out_overflow),
    .pending                 (pending),
    .errors                  (errors)
  );

  // Seen at the next falling edge: was the input beat taken at this edge.
  always @(posedge clk) in_took <= in_valid && in_ready;

  always @(negedge clk) begin
    if (rst_n) out_ready <= calm || ($urandom_range(99) >= 17);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == RUN_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Called and returning at a falling edge; valid stays high on return.
  task automatic send_record(field_t mv, key_t p, key_t s, logic fin);
    while (!calm && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid           <= 1'b1;
    in_move_code       <= mv;
    in_primary_score   <= field_t'(p);
    in_secondary_score <= field_t'(s);
    in_last_record     <= fin;
    do @(negedge clk); while (!in_took);
    sent++;
  endtask

  task automatic hold_until_flushed();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // Key styles: full range, a narrow band full of ties, the extremes, or a mix.
  function automatic key_t pick_key(int style);
    int v;
    if (style == 3) style = $urandom_range(2);
    case (style)
      0: return key_t'($urandom);
      1: begin
        v = $urandom_range(6);
        return key_t'(v - 3);
      end
      default: begin
        case ($urandom_range(4))
          0: return 16'sh8000;
          1: return 16'shFFFF;
          2: return 16'sh0000;
          3: return 16'sh0001;
          default: return 16'sh7FFF;
        endcase
      end
    endcase
  endfunction

  task automatic send_run(int len, int style);
    for (int k = 0; k < len; k++)
      send_record(field_t'($urandom), pick_key(style), pick_key(style), k == len - 1);
  endtask

  initial begin
    int run;
    int len;
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_move_code       = '0;
    in_primary_score   = '0;
    in_secondary_score = '0;
    in_last_record     = 1'b0;
    out_ready          = 1'b0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Single-record runs at the key extremes.
    send_record(16'hFFFF, 32767, -32768, 1'b1);
    send_record(16'h0000, -32768, 32767, 1'b1);
    // Ties on both keys must keep arrival order; the last beat ties as well.
    send_record(16'h0001, 5, 3, 1'b0);
    send_record(16'h0002, 5, 3, 1'b0);
    send_record(16'h0003, 5, 7, 1'b0);
    send_record(16'h0004, -1, 0, 1'b0);
    send_record(16'h0005, 5, 3, 1'b0);
    send_record(16'h0006, 32767, -32768, 1'b0);
    send_record(16'h0007, -32768, 32767, 1'b0);
    send_record(16'h0008, 5, -3, 1'b0);
    send_record(16'h0009, 5, 3, 1'b1);
    // Rising primary keys: every beat goes to the head.
    for (int k = 0; k < 5; k++) send_record(field_t'(16'h0010 + k), key_t'(k), 0, k == 4);
    // Equal primary, rising secondary.
    send_record(16'h0020, -7, -100, 1'b0);
    send_record(16'h0021, -7, -50, 1'b0);
    send_record(16'h0022, -7, 50, 1'b0);
    send_record(16'h0023, -7, 100, 1'b1);
    // Identical keys throughout.
    send_record(16'h0030, 0, 0, 1'b0);
    send_record(16'h0031, 0, 0, 1'b0);
    send_record(16'h0032, 0, 0, 1'b1);
    hold_until_flushed();

    run = 0;
    while (sent < ITEM_TARGET) begin
      calm = (run >= 18 && run < 26);
      // A run that just fills the store, and two that overrun it, one of them
      // by more than a single record.
      case (run)
        3:       len = 65;
        9:       len = 64;
        15:      len = 67;
        default: len = ($urandom_range(9) == 0) ? $urandom_range(13, 30)
                                                : $urandom_range(1, 10);
      endcase
      send_run(len, $urandom_range(3));
      if (run % 7 == 6) hold_until_flushed();
      run++;
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/tksrs_pkg.sv
hw/rtl/tksrs_cell.sv
hw/rtl/tksrs_ctrl.sv
hw/rtl/two_key_stable_record_sorter.sv
tb/sorted_run_checker.sv
tb/tb_two_key_stable_record_sorter.sv
